// ===== rtl/core/penalized_one_objective_macros.svh =====
// assertion macros for the penalized function 1 evaluator
`ifndef PENALIZED_ONE_OBJECTIVE_MACROS_SVH
`define PENALIZED_ONE_OBJECTIVE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define POP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define POP_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pop_pkg.sv =====
// shared types, constants and functions of the penalized function 1 evaluator
package pop_pkg;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam logic [APB_ADDR_W-1:0] REG_NUM_VARIABLES = 4'd0;
	localparam logic [APB_ADDR_W-1:0] REG_BIAS = 4'd8;

	localparam int X_W = 23;
	localparam int OBJ_W = 63;
	localparam int NV_W = 10;
	localparam int BIAS_W = 48;
	localparam int MUL_W = 28;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_NUM_W = 42;
	localparam int DIV_DEN_W = 10;
	localparam int SIN_W = 17;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam logic [21:0] PI_Q20 = 22'd3294199;
	localparam logic [63:0] SUM_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [22:0] TEN_Q16 = 23'd655360;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00_0000_0000_0001,
		ST_SQ   = 14'b00_0000_0000_0010,
		ST_PAIR = 14'b00_0000_0000_0100,
		ST_E2   = 14'b00_0000_0000_1000,
		ST_E4   = 14'b00_0000_0001_0000,
		ST_PEN  = 14'b00_0000_0010_0000,
		ST_ACC  = 14'b00_0000_0100_0000,
		ST_FSUM = 14'b00_0000_1000_0000,
		ST_MLO  = 14'b00_0001_0000_0000,
		ST_MHI  = 14'b00_0010_0000_0000,
		ST_MCMB = 14'b00_0100_0000_0000,
		ST_DIV  = 14'b00_1000_0000_0000,
		ST_FIN  = 14'b01_0000_0000_0000,
		ST_OUT  = 14'b10_0000_0000_0000
	} pop_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] numer;
		logic [DIV_DEN_W-1:0] denom;
	} pop_div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} pop_div_rsp_t;

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64] || s[63]) begin
			return SUM_CAP;
		end
		return s[63:0];
	endfunction

	// sin^2 of pi*idx/2^(bits-1) in q16, evaluated at elaboration
	function automatic logic [SIN_W-1:0] sine_sq_entry(int unsigned bits, int unsigned idx);
		longint unsigned half;
		longint unsigned quarter;
		longint unsigned h;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned a;
		longint unsigned s;
		half = 64'd1 << (bits - 1);
		quarter = 64'd1 << (bits - 2);
		h = longint'(idx) & (half - 64'd1);
		if (h > quarter) begin
			h = half - h;
		end
		t = (h * PI_Q30) >> (bits - 1);
		t2 = (t * t) >> 30;
		a = ONE_Q30 - t2 / 72;
		a = ONE_Q30 - ((t2 * a) >> 30) / 42;
		a = ONE_Q30 - ((t2 * a) >> 30) / 20;
		a = ONE_Q30 - ((t2 * a) >> 30) / 6;
		s = (t * a) >> 30;
		if (s > ONE_Q30) begin
			s = ONE_Q30;
		end
		return SIN_W'((s * s) >> 44);
	endfunction

endpackage

// ===== rtl/core/penalized_one_objective.sv =====
// top level: penalized function 1 evaluator with apb configuration
// Evaluates penalized benchmark function 1 over a vector of num_variables elements, one signed
// q16 element per input beat, and returns one saturated q16 objective beat after the last
// element. Every element passes through one shared 28x28 multiplier four times (square,
// pair product, and the two squarings of the penalty), so the block takes no new element until
// the one before it is through. The closing element adds the final sum, two multiplier passes
// for the pi scaling and a one-bit-per-cycle divide by the vector length; its result sits
// in an output register, so the next vector's first element is taken while the result waits.
// num_variables of zero counts as one and values above MAX_VARIABLES count as MAX_VARIABLES.
// Registers sit on an apb port with 64-bit data: num_variables at 0x0, bias (48-bit signed
// q16) at 0x8.
`include "penalized_one_objective_macros.svh"

module penalized_one_objective #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int MAX_VARIABLES = 1000
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pop_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pop_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pop_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [pop_pkg::X_W-1:0]     variable_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pop_pkg::OBJ_W-1:0]   objective
);
	import pop_pkg::*;

	localparam int TBL_DEPTH = 1 << SINE_TABLE_BITS;
	localparam int CW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;

	pop_state_t state_q;

	logic [NV_W-1:0]   num_variables_q;
	logic [BIAS_W-1:0] bias_q;
	logic              wr_en;

	logic [CW-1:0]  count_q;
	logic [19:0]    first_q;
	logic [23:0]    prev_q;
	logic [63:0]    pair_sum_q;
	logic [63:0]    penalty_sum_q;
	logic           out_valid_q;
	logic [OBJ_W-1:0] objective_q;

	logic [22:0]    mag_q;
	logic [21:0]    e_q;
	logic           pen_on_q;
	logic [SINE_TABLE_BITS-1:0] idx_q;
	logic [19:0]    sin10_q;
	logic [23:0]    sq_q;
	logic [46:0]    pen_term_q;
	logic [63:0]    fsum_q;
	logic [39:0]    s_q;
	logic [41:0]    lo_q;
	logic [62:0]    tmp_q;

	logic signed [23:0] d_in;
	logic [22:0]    mag_in;
	logic [22:0]    ax_in;
	logic [18:0]    phase_in;

	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;

	pop_div_req_t div_req;
	pop_div_rsp_t div_rsp;

	logic [SIN_W-1:0] sine_tbl [TBL_DEPTH];
	logic [SIN_W-1:0] sin_val;
	logic [NV_W-1:0]  n_eff;
	logic             last_elem;
	logic [46:0]      sq_round;
	logic [39:0]      e4;
	logic [63:0]      fsum2;
	logic [61:0]      pcap;
	logic signed [64:0] r_sum;
	logic [OBJ_W-1:0] r_sat;
	logic             out_free;

	for (genvar i = 0; i < TBL_DEPTH; i++) begin : g_tbl
		assign sine_tbl[i] = sine_sq_entry(SINE_TABLE_BITS, i);
	end

	// apb
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_comb begin
		unique case (paddr)
			REG_NUM_VARIABLES: prdata = APB_DATA_W'(num_variables_q);
			REG_BIAS:          prdata = APB_DATA_W'(bias_q);
			default:           prdata = '0;
		endcase
	end

	// element front end
	assign d_in = 24'(variable_value) + 24'sd65536;
	assign mag_in = d_in[23] ? 23'(-d_in) : d_in[22:0];
	assign ax_in = variable_value[22] ? 23'(-variable_value) : variable_value;
	assign phase_in = {~d_in[18], d_in[17:0]};

	always_comb begin
		if (num_variables_q == '0) begin
			n_eff = NV_W'(1);
		end else if (32'(num_variables_q) > MAX_VARIABLES) begin
			n_eff = NV_W'(MAX_VARIABLES);
		end else begin
			n_eff = num_variables_q;
		end
	end

	assign last_elem = (11'(count_q) + 11'd1) >= {1'b0, n_eff};
	assign sin_val = sine_tbl[idx_q];
	assign sq_round = 47'(mul_p[45:0]) + 47'(1 << 19);
	assign e4 = mul_p[55:16];
	assign fsum2 = add_sat(fsum_q, 64'(first_q));
	assign pcap = penalty_sum_q[62] ? {62{1'b1}} : penalty_sum_q[61:0];
	assign r_sum = $signed({2'b00, tmp_q}) + 65'(signed'(bias_q));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (r_sum > 65'sh0_3FFF_FFFF_FFFF_FFFF) begin
			r_sat = {1'b0, {62{1'b1}}};
		end else if (r_sum < -65'sh0_4000_0000_0000_0000) begin
			r_sat = {1'b1, 62'd0};
		end else begin
			r_sat = r_sum[OBJ_W-1:0];
		end
	end

	// shared multiplier operands
	always_comb begin
		unique case (state_q)
			ST_SQ: begin
				mul_a = MUL_W'(mag_q);
				mul_b = MUL_W'(mag_q);
			end
			ST_PAIR: begin
				mul_a = MUL_W'(prev_q);
				mul_b = MUL_W'(21'(sin10_q) + 21'd65536);
			end
			ST_E2: begin
				mul_a = MUL_W'(e_q);
				mul_b = MUL_W'(e_q);
			end
			ST_E4: begin
				mul_a = mul_p[43:16];
				mul_b = mul_p[43:16];
			end
			ST_MLO: begin
				mul_a = MUL_W'(s_q[19:0]);
				mul_b = MUL_W'(PI_Q20);
			end
			ST_MHI: begin
				mul_a = MUL_W'(s_q[39:20]);
				mul_b = MUL_W'(PI_Q20);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pop_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign div_req.start = (state_q == ST_MCMB);
	assign div_req.numer = mul_p[41:0] + 42'(lo_q[41:20]);
	assign div_req.denom = n_eff;

	pop_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and accumulated state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_variables_q <= NV_W'(2);
			bias_q <= '0;
			count_q <= '0;
			first_q <= '0;
			prev_q <= '0;
			pair_sum_q <= '0;
			penalty_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (paddr)
					REG_NUM_VARIABLES: num_variables_q <= pwdata[NV_W-1:0];
					REG_BIAS:          bias_q <= pwdata[BIAS_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ:   state_q <= ST_PAIR;
				ST_PAIR: state_q <= ST_E2;
				ST_E2: begin
					if (count_q == '0) begin
						first_q <= sin10_q;
					end else begin
						pair_sum_q <= add_sat(pair_sum_q, 64'(mul_p[43:16]));
					end
					prev_q <= sq_q;
					state_q <= ST_E4;
				end
				ST_E4:   state_q <= ST_PEN;
				ST_PEN:  state_q <= ST_ACC;
				ST_ACC: begin
					if (pen_on_q) begin
						penalty_sum_q <= add_sat(penalty_sum_q, 64'(pen_term_q));
					end
					if (last_elem) begin
						state_q <= ST_FSUM;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_FSUM: state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_MCMB;
				ST_MCMB: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						count_q <= '0;
						first_q <= '0;
						prev_q <= '0;
						pair_sum_q <= '0;
						penalty_sum_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mag_q <= mag_in;
			e_q <= 22'(ax_in - TEN_Q16);
			pen_on_q <= ax_in > TEN_Q16;
			idx_q <= phase_in[18 -: SINE_TABLE_BITS];
		end
		if (state_q == ST_SQ) begin
			sin10_q <= 20'({sin_val, 3'b000}) + 20'({sin_val, 1'b0});
		end
		if (state_q == ST_PAIR) begin
			sq_q <= (sq_round[46:44] != '0) ? 24'hFF_FFFF : sq_round[43:20];
		end
		if (state_q == ST_PEN) begin
			pen_term_q <= 47'({e4, 6'd0}) + 47'({e4, 5'd0}) + 47'({e4, 2'd0});
		end
		if (state_q == ST_ACC) begin
			fsum_q <= add_sat(pair_sum_q, 64'(sq_q));
		end
		if (state_q == ST_FSUM) begin
			s_q <= (fsum2[63:40] != '0) ? {40{1'b1}} : fsum2[39:0];
		end
		if (state_q == ST_MHI) begin
			lo_q <= mul_p[41:0];
		end
		if (state_q == ST_FIN) begin
			tmp_q <= 63'(div_rsp.quotient) + 63'(pcap);
		end
		if (state_q == ST_OUT && out_free) begin
			objective_q <= r_sat;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign objective = objective_q;

	`POP_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_q == ST_DIV, "divider done outside wait")
	`POP_ASSERT_IMP(a_count_below_max, 1'b1, 32'(count_q) < MAX_VARIABLES, "element count overrun")
	`POP_ASSERT_IMP(a_sums_capped, 1'b1, !pair_sum_q[63] && !penalty_sum_q[63], "sum not saturated")
	`POP_ASSERT_NXT(a_result_clears, state_q == ST_OUT && out_free, out_valid && count_q == '0 && pair_sum_q == '0 && penalty_sum_q == '0, "vector state not cleared")

endmodule

// ===== rtl/core/pop_mul.sv =====
// shared unsigned multiplier with registered product
module pop_mul (
	input  logic                        clk,
	input  logic [pop_pkg::MUL_W-1:0]   a,
	input  logic [pop_pkg::MUL_W-1:0]   b,
	output logic [pop_pkg::PROD_W-1:0]  p
);
	import pop_pkg::*;

	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

// ===== rtl/core/pop_div.sv =====
// restoring divider, one quotient bit per cycle
module pop_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pop_pkg::pop_div_req_t req,
	output pop_pkg::pop_div_rsp_t rsp
);
	import pop_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == CNT_W'(1));
			if (req.start) begin
				cnt_q <= CNT_W'(DIV_NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.numer;
			rem_q <= '0;
			den_q <= req.denom;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule
